// ===== rtl/pec_pkg.sv =====
// Shared types and constants for the pair elastic collision pipeline.
// No dependencies; used by pair_elastic_collision_top.
package pec_pkg;

  localparam int unsigned QBits   = 36;   // quotient bits produced by the divider
  localparam int unsigned RemBits = 67;   // divider partial remainder width
  localparam int unsigned NumBits = 99;   // dx * A numerator width
  localparam int unsigned DivBits = 66;   // divisor (clamped squared distance) width

  localparam logic [39:0] MinDistSqReset = 40'd720575940;

  // Per-item side data that rides along the multiply and divide stages.
  typedef struct packed {
    logic [2:0][31:0]   va;
    logic [2:0][31:0]   vb;
    logic [2:0]         dx_neg;
    logic               appr;
    logic [37:0]        dist_sq;
    logic [DivBits-1:0] bc;
  } carry_t;

endpackage

// ===== rtl/pair_elastic_collision_top.sv =====
// Elastic collision velocity update for two equal-mass spheres, fully pipelined.
// Accepts one pair per cycle whenever the output request is not stalled.
// Most of the pipeline is the bit-per-stage divider: 36 restoring stages, one per quotient bit.
// The whole pipeline advances together and holds while the output request stalls.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the default distance floor.
// Depends on pec_pkg.
module pair_elastic_collision_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_pos_x, a_pos_y, a_pos_z, a_vel_x, a_vel_y, a_vel_z,
  // b_pos_x, b_pos_y, b_pos_z, b_vel_x, b_vel_y, b_vel_z (32 bits each)
  input  logic [383:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // new_a_vel_x, new_a_vel_y, new_a_vel_z, new_b_vel_x, new_b_vel_y, new_b_vel_z,
  // dist_sq (38 bits), two zero pad bits
  output logic [231:0] m_axis_tdata_o,
  // approaching
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [39:0]  cfg_data_i
);

  localparam int unsigned QB = pec_pkg::QBits;
  localparam int unsigned RB = pec_pkg::RemBits;
  localparam int unsigned NB = pec_pkg::NumBits;
  localparam int unsigned DB = pec_pkg::DivBits;

  logic        en;
  logic [39:0] min_q;

  assign cfg_ready_o     = 1'b1;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= pec_pkg::MinDistSqReset;
    end else if (cfg_valid_i) begin
      min_q <= cfg_data_i;
    end
  end

  // Stage 1: differences.
  logic               v1_q;
  logic signed [32:0] dx1_q [3];
  logic signed [32:0] dv1_q [3];
  logic [2:0][31:0]   va1_q, vb1_q;

  // Stage 2: per-axis products.
  logic               v2_q;
  logic signed [65:0] p2_q [3];
  logic [65:0]        s2_q [3];
  logic signed [32:0] dx2_q [3];
  logic [2:0][31:0]   va2_q, vb2_q;

  // Stage 3: dot product and squared distance.
  logic               v3_q;
  logic signed [67:0] a3_q;
  logic [65:0]        b3_q;
  logic signed [32:0] dx3_q [3];
  logic [2:0][31:0]   va3_q, vb3_q;

  // Stage 4: magnitude of A, clamp of B.
  logic               v4_q;
  logic [65:0]        am4_q;
  logic [32:0]        dxm4_q [3];
  pec_pkg::carry_t    c4_q;

  // Stage 5: partial products of dx * A.
  logic               v5_q;
  logic [64:0]        lo5_q [3];
  logic [66:0]        hi5_q [3];
  pec_pkg::carry_t    c5_q;

  // Stage 6: full numerators.
  logic               v6_q;
  logic [NB-1:0]      num6_q [3];
  pec_pkg::carry_t    c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dx1_q[i] <= 33'(signed'(s_axis_tdata_i[32*i +: 32]))
                  - 33'(signed'(s_axis_tdata_i[32*(6+i) +: 32]));
        dv1_q[i] <= 33'(signed'(s_axis_tdata_i[32*(3+i) +: 32]))
                  - 33'(signed'(s_axis_tdata_i[32*(9+i) +: 32]));
        va1_q[i] <= s_axis_tdata_i[32*(3+i) +: 32];
        vb1_q[i] <= s_axis_tdata_i[32*(9+i) +: 32];

        p2_q[i]  <= dv1_q[i] * dx1_q[i];
        s2_q[i]  <= 66'(dx1_q[i] * dx1_q[i]);
        dx2_q[i] <= dx1_q[i];
        dx3_q[i] <= dx2_q[i];
      end
      va2_q <= va1_q;
      vb2_q <= vb1_q;

      a3_q  <= 68'(p2_q[0]) + 68'(p2_q[1]) + 68'(p2_q[2]);
      b3_q  <= s2_q[0] + s2_q[1] + s2_q[2];
      va3_q <= va2_q;
      vb3_q <= vb2_q;

      // A <= 0 means the pair is closing; only then is |A| needed.
      c4_q.appr    <= a3_q[67] || (a3_q == '0);
      am4_q        <= a3_q[67] ? 66'(-a3_q) : '0;
      c4_q.bc      <= (b3_q < 66'(min_q)) ? 66'(min_q) : b3_q;
      c4_q.dist_sq <= b3_q[65:28];
      c4_q.va      <= va3_q;
      c4_q.vb      <= vb3_q;
      for (int i = 0; i < 3; i++) begin
        c4_q.dx_neg[i] <= dx3_q[i][32];
        dxm4_q[i]      <= dx3_q[i][32] ? 33'(-dx3_q[i]) : 33'(dx3_q[i]);
      end

      for (int i = 0; i < 3; i++) begin
        lo5_q[i]  <= 65'(dxm4_q[i]) * 65'(am4_q[31:0]);
        hi5_q[i]  <= 67'(dxm4_q[i]) * 67'(am4_q[65:32]);
        num6_q[i] <= NB'(lo5_q[i]) + {hi5_q[i][NB-33:0], 32'b0};
      end
      c5_q <= c4_q;
      c6_q <= c5_q;
    end
  end

  // Restoring divider, one quotient bit per stage. The quotient is known to stay
  // below 2^36, so the top numerator bits already form a remainder below the divisor.
  logic            dval_q [QB];
  pec_pkg::carry_t dc_q   [QB];
  logic [RB-1:0]   dr_q   [QB][3];
  logic [QB-1:0]   dl_q   [QB][3];
  logic [QB-1:0]   dq_q   [QB][3];

  logic [RB-1:0]   r_in   [QB][3];
  logic [QB-1:0]   l_in   [QB][3];
  logic [QB-1:0]   q_in   [QB][3];
  logic [DB-1:0]   d_in   [QB];
  logic [RB-1:0]   r_nx   [QB][3];
  logic [QB-1:0]   q_nx   [QB][3];
  logic [RB-1:0]   r_sh   [QB][3];
  logic [RB:0]     diff   [QB][3];

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      d_in[j] = (j == 0) ? c6_q.bc : dc_q[(j == 0) ? 0 : j - 1].bc;
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          r_in[j][i] = RB'(num6_q[i][NB-1:QB]);
          l_in[j][i] = num6_q[i][QB-1:0];
          q_in[j][i] = '0;
        end else begin
          r_in[j][i] = dr_q[j-1][i];
          l_in[j][i] = dl_q[j-1][i];
          q_in[j][i] = dq_q[j-1][i];
        end
        r_sh[j][i] = {r_in[j][i][RB-2:0], l_in[j][i][QB-1]};
        diff[j][i] = {1'b0, r_sh[j][i]} - (RB+1)'(d_in[j]);
        if (!diff[j][i][RB]) begin
          r_nx[j][i] = diff[j][i][RB-1:0];
          q_nx[j][i] = {q_in[j][i][QB-2:0], 1'b1};
        end else begin
          r_nx[j][i] = r_sh[j][i];
          q_nx[j][i] = {q_in[j][i][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < QB; j++) dval_q[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < QB; j++) dval_q[j] <= (j == 0) ? v6_q : dval_q[(j == 0) ? 0 : j - 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < QB; j++) begin
        dc_q[j] <= (j == 0) ? c6_q : dc_q[(j == 0) ? 0 : j - 1];
        for (int i = 0; i < 3; i++) begin
          dr_q[j][i] <= r_nx[j][i];
          dl_q[j][i] <= {l_in[j][i][QB-2:0], 1'b0};
          dq_q[j][i] <= q_nx[j][i];
        end
      end
    end
  end

  // Output stage: apply delta and saturate.
  pec_pkg::carry_t    fc;
  logic signed [36:0] delta [3];
  logic signed [37:0] sa [3];
  logic signed [37:0] sb [3];
  logic [2:0][31:0]   na, nb;

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v[37:31] == '0 || v[37:31] == '1) r = v[31:0];
    else if (v[37]) r = 32'h8000_0000;
    else r = 32'h7fff_ffff;
    return r;
  endfunction

  assign fc = dc_q[QB-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // A zero divisor only occurs with a zero numerator; the delta is then forced to zero.
      if (fc.bc == '0) delta[i] = '0;
      else if (fc.dx_neg[i]) delta[i] = 37'(dq_q[QB-1][i]);
      else delta[i] = -37'(dq_q[QB-1][i]);
      sa[i] = 38'(signed'(fc.va[i])) - 38'(delta[i]);
      sb[i] = 38'(signed'(fc.vb[i])) + 38'(delta[i]);
      na[i] = fc.appr ? sat32(sa[i]) : fc.va[i];
      nb[i] = fc.appr ? sat32(sb[i]) : fc.vb[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (en) begin
      m_axis_tvalid_o <= dval_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata_o <= {2'b00, fc.dist_sq, nb, na};
      m_axis_tuser_o <= fc.appr;
    end
  end

  // The final remainder must be below the divisor, or the quotient bound failed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dval_q[QB-1] |-> (fc.bc == '0) ||
      ((dr_q[QB-1][0] < RB'(fc.bc)) && (dr_q[QB-1][1] < RB'(fc.bc)) &&
       (dr_q[QB-1][2] < RB'(fc.bc))))
    else $error("divider remainder not below divisor");

  // Exact quotients never exceed the velocity difference, which is below 2^34.
  // A zero divisor yields a meaningless quotient that the output stage ignores.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dval_q[QB-1] |-> (fc.bc == '0) ||
      ((dq_q[QB-1][0][QB-1:34] == '0) && (dq_q[QB-1][1][QB-1:34] == '0) &&
       (dq_q[QB-1][2][QB-1:34] == '0)))
    else $error("collision delta out of range");

  // A new output request can only come from a valid item in the last divider stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(dval_q[QB-1]))
    else $error("output request without a valid item");

  // A configuration write lands in the floor register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (min_q == $past(cfg_data_i)))
    else $error("distance floor not updated");

endmodule

// ===== verif/pair_elastic_collision_top_test.sv =====
// Self-checking testbench for pair_elastic_collision_top: random and directed sphere pairs,
// random stalls on both streams, and distance floor changes between phases.
// Depends on pec_pkg and the pair_elastic_collision_top RTL.
module pair_elastic_collision_top_test;

  typedef logic [11:0][31:0] pair_t;

  typedef struct packed {
    logic [5:0][31:0] vel;
    logic [37:0]      dsq;
    logic             appr;
  } velocity_update_t;

  localparam int DrainCycles = 60;
  localparam int CycleLimit  = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic         out_ready = 1'b0;
  logic [231:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready_o;
  logic [39:0]  cfg_data = '0;

  pair_t            cur_pair = '0;
  pair_t            pending_pairs[$];
  velocity_update_t expected_updates[$];
  logic [39:0]      floor_sq = pec_pkg::MinDistSqReset;
  int               tx_wait = 0;
  int               rx_wait = 0;
  bit               burst = 1'b0;
  int               mismatches = 0;
  int               cycles = 0;

  always #1 clk_i = ~clk_i;

  pair_elastic_collision_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (cur_pair),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  function automatic velocity_update_t collide(input pair_t p, input logic [39:0] fl);
    logic signed [33:0] dx;
    logic signed [33:0] dv;
    logic signed [69:0] dot;
    logic signed [69:0] d2;
    logic [69:0]        bc;
    logic [69:0]        am;
    logic [127:0]       num;
    logic [127:0]       q;
    logic signed [63:0] delta;
    logic signed [63:0] t;
    velocity_update_t   r;
    dot = '0;
    d2 = '0;
    for (int i = 0; i < 3; i++) begin
      dx = $signed(p[i]) - $signed(p[6+i]);
      dv = $signed(p[3+i]) - $signed(p[9+i]);
      dot = dot + dx * dv;
      d2 = d2 + dx * dx;
    end
    r.dsq = d2[65:28];
    r.appr = (dot <= 0);
    for (int i = 0; i < 3; i++) begin
      r.vel[i] = p[3+i];
      r.vel[3+i] = p[9+i];
    end
    if (r.appr) begin
      bc = (d2 < fl) ? 70'(fl) : d2;
      am = -dot;
      for (int i = 0; i < 3; i++) begin
        dx = $signed(p[i]) - $signed(p[6+i]);
        num = 128'(dx < 0 ? -dx : dx) * 128'(am);
        q = (bc == 0) ? '0 : num / 128'(bc);
        if (q > 128'(64'h100_0000_0000)) q = 128'(64'h100_0000_0000);
        delta = (dx < 0) ? $signed(q[63:0]) : -$signed(q[63:0]);
        for (int s = 0; s < 2; s++) begin
          t = (s == 0) ? $signed(p[3+i]) - delta : $signed(p[9+i]) + delta;
          if (t > 64'sd2147483647) t = 64'sd2147483647;
          if (t < -64'sd2147483648) t = -64'sd2147483648;
          r.vel[3*s+i] = t[31:0];
        end
      end
    end
    return r;
  endfunction

  // Sender: one request per item, with a random gap drawn after each request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && s_axis_tready_o) expected_updates.push_back(collide(cur_pair, floor_sq));
      if (!in_valid || s_axis_tready_o) begin
        if (tx_wait > 0) begin
          tx_wait <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          cur_pair <= pending_pairs.pop_front();
          in_valid <= 1'b1;
          tx_wait <= (burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    velocity_update_t got;
    velocity_update_t want;
    int d;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid_o && out_ready) begin
        got.vel = m_axis_tdata_o[191:0];
        got.dsq = m_axis_tdata_o[229:192];
        got.appr = m_axis_tuser_o[0];
        if (expected_updates.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("Unexpected result %h", got);
        end else begin
          want = expected_updates.pop_front();
          if (got !== want || m_axis_tdata_o[231:230] !== 2'b00) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("Mismatch: expected %h, got %h", want, got);
          end
        end
        d = (burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        rx_wait <= d;
        out_ready <= (d == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic pair_t random_pair(input int kind);
    pair_t p;
    for (int i = 0; i < 12; i++) p[i] = $urandom;
    if (kind != 0) begin
      // Close pair: second sphere sits a small, random offset from the first, or on it for kind 2.
      for (int i = 0; i < 3; i++) begin
        p[i] = $signed(p[i]) >>> 2;
        p[6+i] = (kind == 2) ? p[i] : p[i] + ($signed(32'($urandom)) >>> $urandom_range(4, 31));
        p[3+i] = $signed(p[3+i]) >>> $urandom_range(0, 8);
        p[9+i] = $signed(p[9+i]) >>> $urandom_range(0, 8);
      end
    end
    return p;
  endfunction

  // The queues are checked away from the rising edge so the sender has settled.
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_updates.size() > 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_floor(input logic [39:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    floor_sq = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      pending_pairs.push_back(random_pair(k < 2 ? 0 : (k == 2 ? 2 : 1)));
    end
  endtask

  initial begin
    pair_t p;
    logic [39:0] floors[5];
    floors = '{40'd1, 40'hFF_FFFF_FFFF, 40'd0, 40'd720575940, 40'h0};
    floors[4] = {$urandom, 8'($urandom)};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed pairs under the reset floor.
    pending_pairs.push_back('0);
    pending_pairs.push_back('1);
    p = '0;
    for (int i = 0; i < 3; i++) begin
      p[i] = 32'h7FFF_FFFF;
      p[6+i] = 32'h8000_0000;
      p[3+i] = 32'h8000_0000;
      p[9+i] = 32'h7FFF_FFFF;
    end
    pending_pairs.push_back(p);
    for (int i = 0; i < 3; i++) begin
      p[3+i] = 32'h7FFF_FFFF;
      p[9+i] = 32'h8000_0000;
    end
    pending_pairs.push_back(p);
    p = '0;
    p[0] = 32'h0000_0001;
    p[3] = 32'hF000_0000;
    pending_pairs.push_back(p);
    p[3] = 32'h1000_0000;
    pending_pairs.push_back(p);
    for (int i = 0; i < 8; i++) pending_pairs.push_back(random_pair(2));
    for (int i = 0; i < 8; i++) pending_pairs.push_back(random_pair(1));
    random_phase(30);
    drain();
    foreach (floors[f]) begin
      write_floor(floors[f]);
      burst = (f == 1);
      for (int i = 0; i < 6; i++) pending_pairs.push_back(random_pair(2));
      random_phase(70);
      drain();
    end
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
